>>> hdl/ftpm_pkg.sv
// shared types, constants and helpers of the first-touch page mapper
// no dependencies; used by every module of the block except ftpm_ram

package ftpm_pkg;

    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_IDX_W = $clog2(MAX_PAGES);
    localparam int COUNT_W    = PAGE_IDX_W + 1;
    localparam int TAG_W      = 58;
    localparam int ADDR_W     = 64;
    localparam int OFF_W      = 30;
    localparam int STATUS_W   = 2;
    localparam int LIMIT_W    = 21;
    localparam int SHIFT_W    = 5;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd6;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd30;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1024;

    // status codes of a result
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_TRANSLATE_ENABLE = 2'd0;
    localparam logic [1:0] REG_PAGE_SHIFT       = 2'd1;
    localparam logic [1:0] REG_PHYS_LIMIT_MB    = 2'd2;

    typedef struct packed {
        logic               translate_enable;
        logic [SHIFT_W-1:0] page_shift;
        logic [LIMIT_W-1:0] phys_limit_mb;
    } cfg_t;

    function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] sh);
        logic [SHIFT_W-1:0] res;
        if (sh < SHIFT_MIN) begin
            res = SHIFT_MIN;
        end else if (sh > SHIFT_MAX) begin
            res = SHIFT_MAX;
        end else begin
            res = sh;
        end
        return res;
    endfunction

endpackage

>>> hdl/first_touch_page_mapper_top.sv
// first-touch page mapper: translates virtual byte addresses to physical ones,
// handing out physical pages in order of first touch. the slave stream carries
// one virtual address per request; the master stream returns the physical
// address in tdata and the status in tuser (0 hit or passthrough, 1 new page,
// 2 beyond physical limit, 3 table full). registers sit on the apb port.
// one request is in flight at a time. with translation off a request skips the
// tag scan and goes straight to the result. with translation on the tag ram is
// read one entry per cycle, so a hit ends the scan at its entry and a miss scans
// all pages_used entries; no new request is taken until that scan is done.
// the result sits in an output register: the next request is taken while it
// waits, and a stalled receiver holds a finished lookup until the register
// frees up. reset clears the page count and restores register defaults; tag
// ram contents need no clearing since only installed entries are scanned.
// depends on ftpm_pkg, ftpm_cfg, ftpm_engine, ftpm_ram

module first_touch_page_mapper_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // apb configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ftpm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ftpm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ftpm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ftpm_pkg::ADDR_W-1:0]        s_tdata,   // [63:0] virtual_address
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ftpm_pkg::ADDR_W-1:0]        m_tdata,   // [63:0] physical_address
    output logic [ftpm_pkg::STATUS_W-1:0]      m_tuser    // [1:0] status
);

    ftpm_pkg::cfg_t cfg;

    ftpm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ftpm_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> hdl/ftpm_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies

module ftpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ftpm_cfg.sv
// apb register file: translate enable, page shift, physical limit
// depends on ftpm_pkg

module ftpm_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ftpm_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ftpm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ftpm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output ftpm_pkg::cfg_t                    cfg
);

    ftpm_pkg::cfg_t cfg_reg;
    ftpm_pkg::cfg_t cfg_next;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                ftpm_pkg::REG_TRANSLATE_ENABLE: cfg_next.translate_enable = pwdata[0];
                ftpm_pkg::REG_PAGE_SHIFT:
                    cfg_next.page_shift = pwdata[ftpm_pkg::SHIFT_W-1:0];
                ftpm_pkg::REG_PHYS_LIMIT_MB:
                    cfg_next.phys_limit_mb = pwdata[ftpm_pkg::LIMIT_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.translate_enable <= 1'b1;
            cfg_reg.page_shift       <= ftpm_pkg::SHIFT_RESET;
            cfg_reg.phys_limit_mb    <= ftpm_pkg::LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            ftpm_pkg::REG_TRANSLATE_ENABLE:
                prdata = {31'd0, cfg_reg.translate_enable};
            ftpm_pkg::REG_PAGE_SHIFT:
                prdata = {27'd0, cfg_reg.page_shift};
            ftpm_pkg::REG_PHYS_LIMIT_MB:
                prdata = {11'd0, cfg_reg.phys_limit_mb};
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/ftpm_engine.sv
// lookup engine: scans the page tag ram one entry per cycle, installs new pages
// and holds the result register; depends on ftpm_pkg and ftpm_ram

module ftpm_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ftpm_pkg::cfg_t                      cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ftpm_pkg::ADDR_W-1:0]         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ftpm_pkg::ADDR_W-1:0]         m_tdata,
    output logic [ftpm_pkg::STATUS_W-1:0]       m_tuser
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [ftpm_pkg::COUNT_W-1:0]    used_reg, used_next;
    logic [ftpm_pkg::COUNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                            pipe_v_reg, pipe_v_next;
    logic [ftpm_pkg::PAGE_IDX_W-1:0] pipe_idx_reg, pipe_idx_next;
    logic                            hit_reg, hit_next;
    logic [ftpm_pkg::PAGE_IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic                            passthru_reg, passthru_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    // item payload, no reset needed
    logic [ftpm_pkg::ADDR_W-1:0]   va_reg;
    logic [ftpm_pkg::TAG_W-1:0]    vpn_reg;
    logic [ftpm_pkg::OFF_W-1:0]    off_reg;
    logic [ftpm_pkg::ADDR_W-1:0]   m_tdata_reg;
    logic [ftpm_pkg::STATUS_W-1:0] m_tuser_reg;

    logic [ftpm_pkg::SHIFT_W-1:0] sh;
    logic [ftpm_pkg::ADDR_W-1:0]  va_shifted;
    logic [ftpm_pkg::OFF_W-1:0]   off_mask;
    logic                         accept;
    logic                         issue_ok;
    logic                         rd_en;
    logic [ftpm_pkg::TAG_W-1:0]   rd_data;
    logic                         tag_hit;
    logic [ftpm_pkg::ADDR_W-1:0]  hit_pa, base, limit;
    logic [ftpm_pkg::ADDR_W-1:0]  res_pa;
    logic [ftpm_pkg::STATUS_W-1:0] res_st;
    logic                         install;
    logic                         out_free;
    logic                         commit;

    assign sh         = ftpm_pkg::eff_shift(cfg.page_shift);
    assign va_shifted = s_tdata >> sh;
    assign off_mask   = (30'd1 << sh) - 30'd1;
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid & s_tready;

    assign issue_ok = (issue_idx_reg < used_reg);
    assign rd_en    = (state_reg == ST_SCAN) && issue_ok;
    assign tag_hit  = pipe_v_reg && (rd_data == vpn_reg);

    ftpm_ram #(
        .WIDTH (ftpm_pkg::TAG_W),
        .DEPTH (ftpm_pkg::MAX_PAGES)
    ) u_tags (
        .aclk  (aclk),
        .we    (commit & install),
        .waddr (used_reg[ftpm_pkg::PAGE_IDX_W-1:0]),
        .wdata (vpn_reg),
        .re    (rd_en),
        .raddr (issue_idx_reg[ftpm_pkg::PAGE_IDX_W-1:0]),
        .rdata (rd_data)
    );

    // result of the finished lookup
    assign hit_pa = ({{(ftpm_pkg::ADDR_W-ftpm_pkg::PAGE_IDX_W){1'b0}}, hit_idx_reg} << sh)
                  | {{(ftpm_pkg::ADDR_W-ftpm_pkg::OFF_W){1'b0}}, off_reg};
    assign base   = {{(ftpm_pkg::ADDR_W-ftpm_pkg::COUNT_W){1'b0}}, used_reg} << sh;
    assign limit  = {23'd0, cfg.phys_limit_mb, 20'd0};

    always_comb begin
        install = 1'b0;
        if (passthru_reg) begin
            res_pa = va_reg;
            res_st = ftpm_pkg::ST_OK;
        end else if (hit_reg) begin
            res_pa = hit_pa;
            res_st = ftpm_pkg::ST_OK;
        end else if (base >= limit) begin
            res_pa = '0;
            res_st = ftpm_pkg::ST_LIMIT;
        end else if (used_reg == ftpm_pkg::COUNT_W'(ftpm_pkg::MAX_PAGES)) begin
            res_pa = '0;
            res_st = ftpm_pkg::ST_FULL;
        end else begin
            res_pa  = base | {{(ftpm_pkg::ADDR_W-ftpm_pkg::OFF_W){1'b0}}, off_reg};
            res_st  = ftpm_pkg::ST_NEW;
            install = 1'b1;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_FINISH) && out_free;

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        issue_idx_next = issue_idx_reg;
        pipe_v_next    = pipe_v_reg;
        pipe_idx_next  = pipe_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        passthru_next  = passthru_reg;
        m_tvalid_next  = m_tvalid_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    passthru_next  = !cfg.translate_enable;
                    hit_next       = 1'b0;
                    issue_idx_next = '0;
                    pipe_v_next    = 1'b0;
                    state_next     = cfg.translate_enable ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN: begin
                // read issue one entry ahead of the compare
                pipe_v_next   = issue_ok;
                pipe_idx_next = issue_idx_reg[ftpm_pkg::PAGE_IDX_W-1:0];
                if (issue_ok) begin
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                if (tag_hit) begin
                    hit_next     = 1'b1;
                    hit_idx_next = pipe_idx_reg;
                    state_next   = ST_FINISH;
                end else if (!issue_ok && !pipe_v_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (install) begin
                        used_next = used_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            issue_idx_reg <= '0;
            pipe_v_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            passthru_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            issue_idx_reg <= issue_idx_next;
            pipe_v_reg    <= pipe_v_next;
            hit_reg       <= hit_next;
            passthru_reg  <= passthru_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pipe_idx_reg <= pipe_idx_next;
        hit_idx_reg  <= hit_idx_next;
        if (accept) begin
            va_reg  <= s_tdata;
            vpn_reg <= va_shifted[ftpm_pkg::TAG_W-1:0];
            off_reg <= s_tdata[ftpm_pkg::OFF_W-1:0] & off_mask;
        end
        if (commit) begin
            m_tdata_reg <= res_pa;
            m_tuser_reg <= res_st;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> dv/ftpm_translation_checker.sv
// checker for the first-touch page mapper: snoops apb writes and both streams,
// predicts every translation and compares it with the returned result
// depends on ftpm_pkg; instantiated by tb_first_touch_page_mapper_top
`timescale 1ns / 1ps

module ftpm_translation_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [ftpm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ftpm_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [ftpm_pkg::ADDR_W-1:0]         s_tdata,   // [63:0] virtual_address
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [ftpm_pkg::ADDR_W-1:0]         m_tdata,   // [63:0] physical_address
    input  logic [ftpm_pkg::STATUS_W-1:0]       m_tuser,   // [1:0] status
    output int unsigned                         fail_count,
    output int unsigned                         pending,
    output logic [ftpm_pkg::COUNT_W-1:0]        pages_installed
);
    import ftpm_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]   phys_addr;
        logic [STATUS_W-1:0] status;
    } xlat_result_t;

    xlat_result_t        expected_q[$];
    logic [TAG_W-1:0]    vpn_of_page [MAX_PAGES];
    logic [COUNT_W-1:0]  used_cnt;
    cfg_t                regs;
    int unsigned         errs = 0;

    // pages are handed out in order, so table slot i is physical page i
    function automatic xlat_result_t translate(input logic [ADDR_W-1:0] va);
        xlat_result_t       res;
        logic [SHIFT_W-1:0] sh;
        logic [ADDR_W-1:0]  offset;
        logic [ADDR_W-1:0]  shifted;
        logic [ADDR_W-1:0]  slot_addr;
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  limit;
        logic [TAG_W-1:0]   vpn;
        res.phys_addr = va;
        res.status    = ST_OK;
        if (!regs.translate_enable) begin
            return res;
        end
        sh = regs.page_shift;
        if (sh < SHIFT_MIN) begin
            sh = SHIFT_MIN;
        end else if (sh > SHIFT_MAX) begin
            sh = SHIFT_MAX;
        end
        offset  = va & ((64'd1 << sh) - 64'd1);
        shifted = va >> sh;
        vpn     = shifted[TAG_W-1:0];
        for (int i = 0; i < int'(used_cnt); i++) begin
            if (vpn_of_page[i] == vpn) begin
                slot_addr = '0;
                slot_addr[COUNT_W-1:0] = i[COUNT_W-1:0];
                res.phys_addr = (slot_addr << sh) | offset;
                return res;
            end
        end
        // limit check comes before the full-table check
        limit = {{(ADDR_W-LIMIT_W-20){1'b0}}, regs.phys_limit_mb, 20'd0};
        base  = {{(ADDR_W-COUNT_W){1'b0}}, used_cnt} << sh;
        if (base >= limit) begin
            res.phys_addr = '0;
            res.status    = ST_LIMIT;
        end else if (used_cnt >= MAX_PAGES) begin
            res.phys_addr = '0;
            res.status    = ST_FULL;
        end else begin
            vpn_of_page[used_cnt[PAGE_IDX_W-1:0]] = vpn;
            used_cnt      = used_cnt + 1'b1;
            res.phys_addr = base | offset;
            res.status    = ST_NEW;
        end
        return res;
    endfunction

    always @(posedge aclk) begin : monitor
        xlat_result_t want;
        if (!aresetn) begin
            used_cnt              = '0;
            regs.translate_enable = 1'b1;
            regs.page_shift       = SHIFT_RESET;
            regs.phys_limit_mb    = LIMIT_RESET;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_TRANSLATE_ENABLE: regs.translate_enable = pwdata[0];
                    REG_PAGE_SHIFT:       regs.page_shift       = pwdata[SHIFT_W-1:0];
                    REG_PHYS_LIMIT_MB:    regs.phys_limit_mb    = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result with no request waiting: physical_address %h status %0d",
                           m_tdata, m_tuser);
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.phys_addr) begin
                        $error("physical_address mismatch: expected %h, actual %h",
                               want.phys_addr, m_tdata);
                        errs++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_tuser);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_q.push_back(translate(s_tdata));
            end
        end
        fail_count      <= errs;
        pending         <= expected_q.size();
        pages_installed <= used_cnt;
    end

endmodule

>>> dv/tb_first_touch_page_mapper_top.sv
// top of the first-touch page mapper testbench: clock, reset, apb setup, request
// stimulus and result back-pressure; the verdict comes from the checker's counts
// depends on ftpm_pkg, first_touch_page_mapper_top and ftpm_translation_checker
`timescale 1ns / 1ps

module tb_first_touch_page_mapper_top;
    import ftpm_pkg::*;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam int         IDLE_PCT      = 24;
    localparam int         HISTORY_DEPTH = 32;
    localparam int         TAIL_CYCLES   = 1100;

    logic                    aclk;
    logic                    aresetn  = 1'b0;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [ADDR_W-1:0]       s_tdata  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [ADDR_W-1:0]       m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    int unsigned             fail_count;
    int unsigned             pending;
    logic [COUNT_W-1:0]      pages_installed;

    bit                      no_idle   = 1'b0;
    logic [SHIFT_W-1:0]      cur_shift = SHIFT_RESET;
    logic [ADDR_W-1:0]       touched_q[$];
    logic [ADDR_W-1:0]       early_q[$];

    first_touch_page_mapper_top dut (.*);

    ftpm_translation_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic issue_request(input logic [ADDR_W-1:0] va);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= va;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // leaves psel high so back-to-back writes go straight into the next setup cycle
    task automatic apb_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // upper data bits carry noise, the block must ignore them
    task automatic set_config(input logic en, input logic [SHIFT_W-1:0] sh,
                              input logic [LIMIT_W-1:0] lim_mb, input bit poke_unused);
        logic [APB_DATA_W-1:0] junk;
        drain_results();
        junk = $urandom;
        apb_write(REG_TRANSLATE_ENABLE, {junk[APB_DATA_W-1:1], en});
        apb_write(REG_PAGE_SHIFT, {junk[APB_DATA_W-1:SHIFT_W], sh});
        apb_write(REG_PHYS_LIMIT_MB, {junk[APB_DATA_W-1:LIMIT_W], lim_mb});
        if (poke_unused) begin
            apb_write(REG_UNUSED, $urandom);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sh < SHIFT_MIN) begin
            cur_shift = SHIFT_MIN;
        end else if (sh > SHIFT_MAX) begin
            cur_shift = SHIFT_MAX;
        end else begin
            cur_shift = sh;
        end
    endtask

    // mostly shifts of 10 or less so the table can fill within any nonzero limit
    task automatic configure_random();
        logic [31:0] sh_pick;
        logic [31:0] lim_pick;
        sh_pick  = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 10) : $urandom_range(0, 31);
        lim_pick = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 32'h1F_FFFF)
                                               : $urandom_range(0, 3);
        set_config($urandom_range(0, 9) != 0, sh_pick[SHIFT_W-1:0], lim_pick[LIMIT_W-1:0],
                   $urandom_range(0, 9) == 0);
    endtask

    // fresh pages, or a page touched before, mostly with a new offset (early pages scan fast)
    function automatic logic [ADDR_W-1:0] next_address(input int unsigned fresh_pct);
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] noise;
        logic [ADDR_W-1:0] page_mask;
        int unsigned       roll;
        roll  = $urandom_range(0, 99);
        noise = {$urandom, $urandom};
        if (roll < fresh_pct || touched_q.size() == 0) begin
            va = ($urandom_range(0, 4) == 0) ? {44'd0, noise[19:0]} : noise;
        end else begin
            if ($urandom_range(0, 1) == 0) begin
                va = early_q[$urandom_range(0, early_q.size() - 1)];
            end else begin
                va = touched_q[$urandom_range(0, touched_q.size() - 1)];
            end
            page_mask = (64'd1 << cur_shift) - 64'd1;
            if (roll % 4 != 0) begin
                va = (va & ~page_mask) | (noise & page_mask);
            end
        end
        return va;
    endfunction

    task automatic send_mix(input int unsigned n_items, input int unsigned fresh_pct);
        logic [ADDR_W-1:0] va;
        for (int unsigned k = 0; k < n_items; k++) begin
            va = next_address(fresh_pct);
            issue_request(va);
            touched_q.push_back(va);
            if (touched_q.size() > HISTORY_DEPTH) begin
                touched_q.delete(0);
            end
            if (early_q.size() < HISTORY_DEPTH) begin
                early_q.push_back(va);
            end
            // now and then hold off until every result is back
            if ($urandom_range(0, 63) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin : stimulus
        int unsigned phase;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults after reset: translation on, 4 KiB pages, 1 GiB
        issue_request(64'h0000_0000_0000_0000);
        issue_request(64'h0000_0000_0000_0FFF);
        issue_request(64'hFFFF_FFFF_FFFF_FFFF);
        issue_request(64'hFFFF_FFFF_FFFF_F000);
        issue_request(64'h8000_0000_0000_0000);
        issue_request(64'h5555_5555_5555_5555);
        issue_request(64'hAAAA_AAAA_AAAA_AAAA);

        // passthrough
        set_config(1'b0, 5'd12, 21'd1024, 1'b0);
        issue_request(64'hFFFF_FFFF_FFFF_FFFF);
        issue_request(64'h0000_0000_0000_0000);
        issue_request({$urandom, $urandom});

        // shift below range acts as 64-byte pages, old tags stay put
        set_config(1'b1, 5'd0, 21'd1024, 1'b0);
        issue_request(64'h0000_0000_0000_0020);
        issue_request(64'hFFFF_FFFF_FFFF_FFFF);

        // shift above range acts as 1 GiB pages, a new page overruns the limit
        set_config(1'b1, 5'd31, 21'd1024, 1'b0);
        issue_request(64'h0000_0000_3FFF_FFFF);
        issue_request(64'h0000_0000_4000_0000);

        // zero limit: misses fail, hits still resolve; unused register poked
        set_config(1'b1, 5'd20, 21'd0, 1'b1);
        issue_request(64'h1234_5678_9ABC_DEF0);
        issue_request(64'h0000_0000_0000_0000);

        set_config(1'b1, 5'd20, 21'd1, 1'b0);
        issue_request({$urandom, $urandom});

        set_config(1'b1, 5'd6, 21'h1F_FFFF, 1'b0);
        issue_request(64'h0000_0000_00C0_FFEE);
        issue_request(64'h0000_0000_00C0_FFEE);

        set_config(1'b1, 5'd12, 21'd1048576, 1'b0);

        // a few random phases
        phase = 0;
        while (pages_installed < MAX_PAGES && phase < 8) begin
            no_idle = (phase == 2);
            configure_random();
            send_mix($urandom_range(40, 80), 70);
            phase++;
        end
        no_idle = 1'b0;

        // small pages with the widest limit, then one more random setup
        set_config(1'b1, 5'd6, 21'h1F_FFFF, 1'b0);
        send_mix(40, 40);
        configure_random();
        send_mix(40, 30);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/ftpm_pkg.sv
hdl/ftpm_ram.sv
hdl/ftpm_cfg.sv
hdl/ftpm_engine.sv
hdl/first_touch_page_mapper_top.sv
dv/ftpm_translation_checker.sv
dv/tb_first_touch_page_mapper_top.sv
